// ===== hw/rtl/host_traffic_counter_table_unit_macros.svh =====
// Assertion macros for the host traffic counter table.
// Included by the modules that carry checks; relies on clk and rst_n in scope.
`ifndef HOST_TRAFFIC_COUNTER_TABLE_UNIT_MACROS_SVH
`define HOST_TRAFFIC_COUNTER_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define HTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HTC_ASSERT(lbl, prop, msg)
`define HTC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/htc_pkg.sv =====
// Shared types, codes and helpers of the host traffic counter table.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package htc_pkg;

  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_HOST_RD = 2'd1;
  localparam logic [1:0] OP_PORT_RD = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_HOST_FULL = 2'd1;
  localparam logic [1:0] ST_PORT_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_ICMP  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // One counter group: inbound bytes, inbound packets, outbound bytes, outbound packets.
  localparam int GRP_W = 192;
  localparam int PKEY_W = 49;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_H_RD,
    CMD_H_NEXT,
    CMD_H_HIT,
    CMD_H_ALLOC,
    CMD_H_ZERO,
    CMD_HC_RD,
    CMD_HC_WR,
    CMD_P_RD,
    CMD_P_NEXT,
    CMD_P_HIT,
    CMD_P_ALLOC,
    CMD_P_ZERO,
    CMD_PC_RD,
    CMD_PC_WR,
    CMD_RD_HOST,
    CMD_RD_PORT,
    CMD_RESULT
  } htc_cmd_op_t;

  typedef struct packed {
    htc_cmd_op_t op;
    logic [1:0]  status;
  } htc_cmd_t;

  typedef struct packed {
    logic h_end;
    logic h_full;
    logic h_match;
    logic p_end;
    logic p_full;
    logic p_match;
    logic need_port;
    logic rd_host_ok;
    logic rd_port_ok;
    logic zero_last;
    logic out_free;
  } htc_sts_t;

  function automatic logic [1:0] proto_class(input logic [7:0] proto);
    logic [1:0] c;
    if (proto == PROTO_TCP) c = CLS_TCP;
    else if (proto == PROTO_UDP) c = CLS_UDP;
    else if (proto == PROTO_ICMP) c = CLS_ICMP;
    else c = CLS_OTHER;
    return c;
  endfunction

  // Adds one packet and len bytes to the inbound or outbound half of a group.
  function automatic logic [GRP_W-1:0] grp_add(input logic [GRP_W-1:0] g,
                                              input logic outbound,
                                              input logic [15:0] len);
    logic [GRP_W-1:0] r;
    r = g;
    if (!outbound) begin
      r[191:128] = g[191:128] + {48'd0, len};
      r[127:96]  = g[127:96] + 32'd1;
    end else begin
      r[95:32] = g[95:32] + {48'd0, len};
      r[31:0]  = g[31:0] + 32'd1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/htc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module htc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/htc_ctrl.sv =====
// Controller state machine of the host traffic counter table.
// Depends on htc_pkg; drives commands into htc_dp and reads its status.
`timescale 1ns / 1ps
module htc_ctrl import htc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_stall,
  input  htc_sts_t   sts,
  output htc_cmd_t   cmd
);
  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CLR    = 15'b000000000000010,
    S_RD     = 15'b000000000000100,
    S_RDWAIT = 15'b000000000001000,
    S_HSCAN  = 15'b000000000010000,
    S_HCMP   = 15'b000000000100000,
    S_HZERO  = 15'b000000001000000,
    S_HCRD   = 15'b000000010000000,
    S_HCWR   = 15'b000000100000000,
    S_PSCAN  = 15'b000001000000000,
    S_PCMP   = 15'b000010000000000,
    S_PZERO  = 15'b000100000000000,
    S_PCRD   = 15'b001000000000000,
    S_PCWR   = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } htc_state_t;

  htc_state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    cmd.op     = CMD_NONE;
    cmd.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          op_nxt     = in_operation;
          status_nxt = ST_OK;
          unique case (in_operation)
            OP_RECORD:  state_nxt = S_HSCAN;
            OP_CLEAR:   state_nxt = S_CLR;
            default:    state_nxt = S_RD;
          endcase
        end
      end
      S_CLR: begin
        cmd.op    = CMD_CLEAR;
        state_nxt = S_DONE;
      end
      S_RD: begin
        if (op_r == OP_HOST_RD && sts.rd_host_ok) begin
          cmd.op    = CMD_RD_HOST;
          state_nxt = S_RDWAIT;
        end else if (op_r == OP_PORT_RD && sts.rd_port_ok) begin
          cmd.op    = CMD_RD_PORT;
          state_nxt = S_RDWAIT;
        end else begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end
      end
      S_RDWAIT: state_nxt = S_DONE;
      S_HSCAN: begin
        if (!sts.h_end) begin
          cmd.op    = CMD_H_RD;
          state_nxt = S_HCMP;
        end else if (sts.h_full) begin
          status_nxt = ST_HOST_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = CMD_H_ALLOC;
          state_nxt = S_HZERO;
        end
      end
      S_HCMP: begin
        if (sts.h_match) begin
          cmd.op    = CMD_H_HIT;
          state_nxt = S_HCRD;
        end else begin
          cmd.op    = CMD_H_NEXT;
          state_nxt = S_HSCAN;
        end
      end
      S_HZERO: begin
        cmd.op = CMD_H_ZERO;
        if (sts.zero_last) state_nxt = S_HCRD;
      end
      S_HCRD: begin
        cmd.op    = CMD_HC_RD;
        state_nxt = S_HCWR;
      end
      S_HCWR: begin
        cmd.op    = CMD_HC_WR;
        state_nxt = sts.need_port ? S_PSCAN : S_DONE;
      end
      S_PSCAN: begin
        if (!sts.p_end) begin
          cmd.op    = CMD_P_RD;
          state_nxt = S_PCMP;
        end else if (sts.p_full) begin
          status_nxt = ST_PORT_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = CMD_P_ALLOC;
          state_nxt = S_PZERO;
        end
      end
      S_PCMP: begin
        if (sts.p_match) begin
          cmd.op    = CMD_P_HIT;
          state_nxt = S_PCRD;
        end else begin
          cmd.op    = CMD_P_NEXT;
          state_nxt = S_PSCAN;
        end
      end
      S_PZERO: begin
        cmd.op    = CMD_P_ZERO;
        state_nxt = S_PCRD;
      end
      S_PCRD: begin
        cmd.op    = CMD_PC_RD;
        state_nxt = S_PCWR;
      end
      S_PCWR: begin
        cmd.op    = CMD_PC_WR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= OP_RECORD;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
endmodule

// ===== hw/rtl/htc_dp.sv =====
// Datapath of the host traffic counter table: key and counter memories,
// fill counts, scan pointers and the result register. Depends on htc_pkg, htc_ram.
`timescale 1ns / 1ps
`include "host_traffic_counter_table_unit_macros.svh"
module htc_dp import htc_pkg::*; #(
  parameter int HOST_SLOTS = 256,
  parameter int PORT_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  htc_cmd_t    cmd,
  output htc_sts_t    sts,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_host_addr,
  input  logic [7:0]  in_ip_proto,
  input  logic [1:0]  in_direction,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_payload_len,
  input  logic [9:0]  in_entry_index,
  input  logic [1:0]  in_class_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_slot_valid,
  output logic [31:0] out_host_addr_out,
  output logic [15:0] out_port_out,
  output logic [1:0]  out_class_out,
  output logic [63:0] out_in_byte_count,
  output logic [31:0] out_in_pkt_count,
  output logic [63:0] out_out_byte_count,
  output logic [31:0] out_out_pkt_count
);
  localparam int HI_W = $clog2(HOST_SLOTS);
  localparam int HC_W = $clog2(HOST_SLOTS + 1);
  localparam int PI_W = $clog2(PORT_SLOTS);
  localparam int PC_W = $clog2(PORT_SLOTS + 1);

  // Captured transaction fields.
  logic [1:0]  op_r;
  logic [31:0] addr_r;
  logic [1:0]  cls_r;
  logic [1:0]  dir_r;
  logic [15:0] port_r;
  logic [15:0] len_r;
  logic [9:0]  idx_r;
  logic [1:0]  csel_r;

  // Slots are handed out lowest first and freed only by a full clear, so the
  // live entries are always the prefix below the fill count.
  logic [HC_W-1:0] hcount_r, hscan_r;
  logic [PC_W-1:0] pcount_r, pscan_r;
  logic [HI_W-1:0] hslot_r;
  logic [PI_W-1:0] pslot_r;
  logic [1:0]      zcnt_r;

  logic                  out_valid_r;
  logic [1:0]            o_status_r;
  logic                  o_valid_slot_r;
  logic [31:0]           o_host_r;
  logic [15:0]           o_port_r;
  logic [1:0]            o_class_r;
  logic [GRP_W-1:0]      o_grp_r;

  // Memory ports.
  logic                  hk_we, hk_re;
  logic [HI_W-1:0]       hk_waddr, hk_raddr;
  logic [31:0]           hk_rdata;
  logic                  hc_we, hc_re;
  logic [HI_W+1:0]       hc_waddr, hc_raddr;
  logic [GRP_W-1:0]      hc_wdata, hc_rdata;
  logic                  pk_we, pk_re;
  logic [PI_W-1:0]       pk_waddr, pk_raddr;
  logic [PKEY_W-1:0]     pk_wdata, pk_rdata;
  logic                  pc_we, pc_re;
  logic [PI_W-1:0]       pc_waddr, pc_raddr;
  logic [GRP_W-1:0]      pc_wdata, pc_rdata;

  logic counting;
  logic ok_host, ok_port;

  assign counting = (dir_r == 2'd0) || (dir_r == 2'd1);
  assign pk_wdata = {addr_r, port_r, cls_r[0]};

  always_comb begin
    hk_we    = (cmd.op == CMD_H_ALLOC);
    hk_waddr = hcount_r[HI_W-1:0];
    hk_re    = (cmd.op == CMD_H_RD) || (cmd.op == CMD_RD_HOST);
    hk_raddr = (cmd.op == CMD_RD_HOST) ? HI_W'(idx_r) : hscan_r[HI_W-1:0];

    hc_we    = (cmd.op == CMD_H_ZERO) || (cmd.op == CMD_HC_WR && counting);
    hc_waddr = (cmd.op == CMD_H_ZERO) ? {hslot_r, zcnt_r} : {hslot_r, cls_r};
    hc_wdata = (cmd.op == CMD_H_ZERO) ? '0 : grp_add(hc_rdata, dir_r[0], len_r);
    hc_re    = (cmd.op == CMD_HC_RD) || (cmd.op == CMD_RD_HOST);
    hc_raddr = (cmd.op == CMD_RD_HOST) ? {HI_W'(idx_r), csel_r} : {hslot_r, cls_r};

    pk_we    = (cmd.op == CMD_P_ALLOC);
    pk_waddr = pcount_r[PI_W-1:0];
    pk_re    = (cmd.op == CMD_P_RD) || (cmd.op == CMD_RD_PORT);
    pk_raddr = (cmd.op == CMD_RD_PORT) ? PI_W'(idx_r) : pscan_r[PI_W-1:0];

    pc_we    = (cmd.op == CMD_P_ZERO) || (cmd.op == CMD_PC_WR && counting);
    pc_waddr = pslot_r;
    pc_wdata = (cmd.op == CMD_P_ZERO) ? '0 : grp_add(pc_rdata, dir_r[0], len_r);
    pc_re    = (cmd.op == CMD_PC_RD) || (cmd.op == CMD_RD_PORT);
    pc_raddr = (cmd.op == CMD_RD_PORT) ? PI_W'(idx_r) : pslot_r;
  end

  htc_ram #(.WIDTH(32), .DEPTH(HOST_SLOTS)) u_hkey (
    .clk(clk), .we(hk_we), .waddr(hk_waddr), .wdata(addr_r),
    .re(hk_re), .raddr(hk_raddr), .rdata(hk_rdata)
  );
  htc_ram #(.WIDTH(GRP_W), .DEPTH(HOST_SLOTS * 4)) u_hcnt (
    .clk(clk), .we(hc_we), .waddr(hc_waddr), .wdata(hc_wdata),
    .re(hc_re), .raddr(hc_raddr), .rdata(hc_rdata)
  );
  htc_ram #(.WIDTH(PKEY_W), .DEPTH(PORT_SLOTS)) u_pkey (
    .clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
    .re(pk_re), .raddr(pk_raddr), .rdata(pk_rdata)
  );
  htc_ram #(.WIDTH(GRP_W), .DEPTH(PORT_SLOTS)) u_pcnt (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .re(pc_re), .raddr(pc_raddr), .rdata(pc_rdata)
  );

  always_comb begin
    sts.h_end      = (hscan_r == hcount_r);
    sts.h_full     = (hcount_r == HC_W'(HOST_SLOTS));
    sts.h_match    = (hk_rdata == addr_r);
    sts.p_end      = (pscan_r == pcount_r);
    sts.p_full     = (pcount_r == PC_W'(PORT_SLOTS));
    sts.p_match    = (pk_rdata == pk_wdata);
    sts.need_port  = (cls_r == CLS_TCP || cls_r == CLS_UDP) && (port_r != 16'd0);
    sts.rd_host_ok = ({22'd0, idx_r} < 32'(hcount_r));
    sts.rd_port_ok = ({22'd0, idx_r} < 32'(pcount_r));
    sts.zero_last  = (zcnt_r == 2'd3);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign ok_host = (op_r == OP_HOST_RD) && (cmd.status == ST_OK);
  assign ok_port = (op_r == OP_PORT_RD) && (cmd.status == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      op_r   <= in_operation;
      addr_r <= in_host_addr;
      cls_r  <= proto_class(in_ip_proto);
      dir_r  <= in_direction;
      port_r <= in_port_number;
      len_r  <= in_payload_len;
      idx_r  <= in_entry_index;
      csel_r <= in_class_select;
    end
    if (cmd.op == CMD_H_HIT) hslot_r <= hscan_r[HI_W-1:0];
    if (cmd.op == CMD_H_ALLOC) hslot_r <= hcount_r[HI_W-1:0];
    if (cmd.op == CMD_P_HIT) pslot_r <= pscan_r[PI_W-1:0];
    if (cmd.op == CMD_P_ALLOC) pslot_r <= pcount_r[PI_W-1:0];
    if (cmd.op == CMD_H_ALLOC) zcnt_r <= 2'd0;
    else if (cmd.op == CMD_H_ZERO) zcnt_r <= zcnt_r + 2'd1;
    if (cmd.op == CMD_RESULT) begin
      o_status_r     <= cmd.status;
      o_valid_slot_r <= ok_host || ok_port;
      o_host_r       <= ok_host ? hk_rdata : (ok_port ? pk_rdata[48:17] : 32'd0);
      o_port_r       <= ok_port ? pk_rdata[16:1] : 16'd0;
      o_class_r      <= ok_host ? csel_r : (ok_port ? {1'b0, pk_rdata[0]} : 2'd0);
      o_grp_r        <= ok_host ? hc_rdata : (ok_port ? pc_rdata : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcount_r    <= '0;
      pcount_r    <= '0;
      hscan_r     <= '0;
      pscan_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == CMD_LOAD) begin
        hscan_r <= '0;
        pscan_r <= '0;
      end
      if (cmd.op == CMD_H_NEXT) hscan_r <= hscan_r + HC_W'(1);
      if (cmd.op == CMD_P_NEXT) pscan_r <= pscan_r + PC_W'(1);
      if (cmd.op == CMD_CLEAR) begin
        hcount_r <= '0;
        pcount_r <= '0;
      end
      if (cmd.op == CMD_H_ALLOC) hcount_r <= hcount_r + HC_W'(1);
      if (cmd.op == CMD_P_ALLOC) pcount_r <= pcount_r + PC_W'(1);
      if (cmd.op == CMD_RESULT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_slot_valid     = o_valid_slot_r;
  assign out_host_addr_out  = o_host_r;
  assign out_port_out       = o_port_r;
  assign out_class_out      = o_class_r;
  assign out_in_byte_count  = o_grp_r[191:128];
  assign out_in_pkt_count   = o_grp_r[127:96];
  assign out_out_byte_count = o_grp_r[95:32];
  assign out_out_pkt_count  = o_grp_r[31:0];

  `HTC_NEVER(a_hcount_range, hcount_r > HC_W'(HOST_SLOTS), "host fill count beyond table size")
  `HTC_NEVER(a_pcount_range, pcount_r > PC_W'(PORT_SLOTS), "port fill count beyond table size")
  `HTC_ASSERT(a_halloc_room, cmd.op == CMD_H_ALLOC |-> !sts.h_full, "host alloc into full table")
  `HTC_ASSERT(a_palloc_room, cmd.op == CMD_P_ALLOC |-> !sts.p_full, "port alloc into full table")
  `HTC_ASSERT(a_result_shown, cmd.op == CMD_RESULT |=> out_valid_r, "result not presented")
endmodule

// ===== hw/rtl/host_traffic_counter_table_unit.sv =====
// Top level of the host traffic counter table: controller plus datapath.
// Depends on htc_pkg, htc_ctrl, htc_dp (and htc_ram through htc_dp).
//
//   Channel  Handshake           Payload
//   in_      in_valid/in_stall   operation, host, protocol, direction, port, length, index, class select
//   out_     out_valid/out_stall status, slot flag, host, port, class, four counters
//
// One transaction is worked on at a time; the result register lets the next one
// enter while a result waits. A record compares the host entries one at a time,
// then, for TCP or UDP with a nonzero port, the port entries, as each key memory has
// a single read port; then come the allocation, counter updates and result.
// Reset is synchronous; the fill counts reset to empty, so no clearing pass runs.
`timescale 1ns / 1ps
module host_traffic_counter_table_unit import htc_pkg::*; #(
  parameter int HOST_SLOTS = 256,
  parameter int PORT_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_host_addr,
  input  logic [7:0]  in_ip_proto,
  input  logic [1:0]  in_direction,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_payload_len,
  input  logic [9:0]  in_entry_index,
  input  logic [1:0]  in_class_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_slot_valid,
  output logic [31:0] out_host_addr_out,
  output logic [15:0] out_port_out,
  output logic [1:0]  out_class_out,
  output logic [63:0] out_in_byte_count,
  output logic [31:0] out_in_pkt_count,
  output logic [63:0] out_out_byte_count,
  output logic [31:0] out_out_pkt_count
);
  htc_cmd_t cmd;
  htc_sts_t sts;

  htc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_operation(in_operation),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  htc_dp #(.HOST_SLOTS(HOST_SLOTS), .PORT_SLOTS(PORT_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_host_addr(in_host_addr),
    .in_ip_proto(in_ip_proto), .in_direction(in_direction),
    .in_port_number(in_port_number), .in_payload_len(in_payload_len),
    .in_entry_index(in_entry_index), .in_class_select(in_class_select),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot_valid(out_slot_valid), .out_host_addr_out(out_host_addr_out),
    .out_port_out(out_port_out), .out_class_out(out_class_out),
    .out_in_byte_count(out_in_byte_count), .out_in_pkt_count(out_in_pkt_count),
    .out_out_byte_count(out_out_byte_count), .out_out_pkt_count(out_out_pkt_count)
  );
endmodule

// ===== verif/tb_host_traffic_counter_table_unit.sv =====
// Self-checking testbench for host_traffic_counter_table_unit.
// Depends on htc_pkg and the RTL of the block; a scoreboard class predicts
// every result from the accepted transactions.
`timescale 1ns / 1ps
module tb_host_traffic_counter_table_unit import htc_pkg::*; ();

  localparam int HOSTS = 256;
  localparam int PORTS = 1024;
  localparam logic [1:0] DIR_IN   = 2'd0;
  localparam logic [1:0] DIR_OUT  = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] host;
    logic [7:0]  proto;
    logic [1:0]  dir;
    logic [15:0] port;
    logic [15:0] len;
    logic [9:0]  idx;
    logic [1:0]  csel;
  } packet_t;

  typedef struct {
    logic [1:0]  status;
    logic        valid;
    logic [31:0] host;
    logic [15:0] port;
    logic [1:0]  cls;
    logic [63:0] rx_bytes;
    logic [31:0] rx_pkts;
    logic [63:0] tx_bytes;
    logic [31:0] tx_pkts;
  } tally_t;

  class traffic_scoreboard;
    bit          h_used[HOSTS];
    logic [31:0] h_key[HOSTS];
    logic [63:0] h_bytes[HOSTS][4][2];
    logic [31:0] h_pkts[HOSTS][4][2];
    bit          p_used[PORTS];
    logic [31:0] p_host[PORTS];
    logic [15:0] p_port[PORTS];
    logic        p_udp[PORTS];
    logic [63:0] p_bytes[PORTS][2];
    logic [31:0] p_pkts[PORTS][2];
    tally_t      pending_tallies[$];
    int          errors;
    int          checked;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function logic [1:0] class_of(logic [7:0] proto);
      case (proto)
        PROTO_TCP:  return CLS_TCP;
        PROTO_UDP:  return CLS_UDP;
        PROTO_ICMP: return CLS_ICMP;
        default:    return CLS_OTHER;
      endcase
    endfunction

    // Finds the host entry or claims the lowest free slot; -1 when full.
    function int host_slot(logic [31:0] addr);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < HOSTS; i++) begin
        if (h_used[i]) begin
          if (h_key[i] == addr) return i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        h_used[free_slot] = 1;
        h_key[free_slot] = addr;
        for (int c = 0; c < 4; c++)
          for (int d = 0; d < 2; d++) begin
            h_bytes[free_slot][c][d] = '0;
            h_pkts[free_slot][c][d] = '0;
          end
      end
      return free_slot;
    endfunction

    function int port_slot(logic [31:0] addr, logic [15:0] port, logic udp);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < PORTS; i++) begin
        if (p_used[i]) begin
          if (p_host[i] == addr && p_port[i] == port && p_udp[i] == udp) return i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        p_used[free_slot] = 1;
        p_host[free_slot] = addr;
        p_port[free_slot] = port;
        p_udp[free_slot] = udp;
        for (int d = 0; d < 2; d++) begin
          p_bytes[free_slot][d] = '0;
          p_pkts[free_slot][d] = '0;
        end
      end
      return free_slot;
    endfunction

    function void note_input(packet_t p);
      tally_t r;
      int h;
      int s;
      logic [1:0] c;
      r = '{default: '0};
      case (p.op)
        OP_RECORD: begin
          c = class_of(p.proto);
          h = host_slot(p.host);
          if (h < 0) begin
            r.status = ST_HOST_FULL;
          end else begin
            if (p.dir == DIR_IN || p.dir == DIR_OUT) begin
              h_bytes[h][c][p.dir[0]] += {48'd0, p.len};
              h_pkts[h][c][p.dir[0]] += 32'd1;
            end
            if ((c == CLS_TCP || c == CLS_UDP) && p.port != 16'd0) begin
              s = port_slot(p.host, p.port, c[0]);
              if (s < 0) begin
                r.status = ST_PORT_FULL;
              end else if (p.dir == DIR_IN || p.dir == DIR_OUT) begin
                p_bytes[s][p.dir[0]] += {48'd0, p.len};
                p_pkts[s][p.dir[0]] += 32'd1;
              end
            end
          end
        end
        OP_HOST_RD: begin
          if (p.idx >= HOSTS || !h_used[p.idx]) begin
            r.status = ST_EMPTY;
          end else begin
            r.valid = 1;
            r.host = h_key[p.idx];
            r.cls = p.csel;
            r.rx_bytes = h_bytes[p.idx][p.csel][0];
            r.rx_pkts = h_pkts[p.idx][p.csel][0];
            r.tx_bytes = h_bytes[p.idx][p.csel][1];
            r.tx_pkts = h_pkts[p.idx][p.csel][1];
          end
        end
        OP_PORT_RD: begin
          if (p.idx >= PORTS || !p_used[p.idx]) begin
            r.status = ST_EMPTY;
          end else begin
            r.valid = 1;
            r.host = p_host[p.idx];
            r.port = p_port[p.idx];
            r.cls = {1'b0, p_udp[p.idx]};
            r.rx_bytes = p_bytes[p.idx][0];
            r.rx_pkts = p_pkts[p.idx][0];
            r.tx_bytes = p_bytes[p.idx][1];
            r.tx_pkts = p_pkts[p.idx][1];
          end
        end
        default: begin
          for (int i = 0; i < HOSTS; i++) h_used[i] = 0;
          for (int i = 0; i < PORTS; i++) p_used[i] = 0;
        end
      endcase
      pending_tallies.push_back(r);
    endfunction

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(tally_t g);
      tally_t e;
      if (pending_tallies.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      e = pending_tallies.pop_front();
      checked++;
      cmp("status", 64'(g.status), 64'(e.status));
      cmp("slot_valid", 64'(g.valid), 64'(e.valid));
      cmp("host_addr_out", 64'(g.host), 64'(e.host));
      cmp("port_out", 64'(g.port), 64'(e.port));
      cmp("class_out", 64'(g.cls), 64'(e.cls));
      cmp("in_byte_count", g.rx_bytes, e.rx_bytes);
      cmp("in_pkt_count", 64'(g.rx_pkts), 64'(e.rx_pkts));
      cmp("out_byte_count", g.tx_bytes, e.tx_bytes);
      cmp("out_pkt_count", 64'(g.tx_pkts), 64'(e.tx_pkts));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_host_addr;
  logic [7:0]  in_ip_proto;
  logic [1:0]  in_direction;
  logic [15:0] in_port_number;
  logic [15:0] in_payload_len;
  logic [9:0]  in_entry_index;
  logic [1:0]  in_class_select;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_slot_valid;
  logic [31:0] out_host_addr_out;
  logic [15:0] out_port_out;
  logic [1:0]  out_class_out;
  logic [63:0] out_in_byte_count;
  logic [31:0] out_in_pkt_count;
  logic [63:0] out_out_byte_count;
  logic [31:0] out_out_pkt_count;

  host_traffic_counter_table_unit DUT (.*);

  traffic_scoreboard sb = new();
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int          hold_left;
  longint      cycles;
  int          n_record;
  int          n_read;
  int          n_clear;
  logic [31:0] host_pool[8];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("** host_traffic_counter_table_unit: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_stall = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    tally_t g;
    packet_t p;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        p = '{in_operation, in_host_addr, in_ip_proto, in_direction, in_port_number,
              in_payload_len, in_entry_index, in_class_select};
        sb.note_input(p);
      end
      if (out_valid && !out_stall) begin
        g = '{out_status, out_slot_valid, out_host_addr_out, out_port_out, out_class_out,
              out_in_byte_count, out_in_pkt_count, out_out_byte_count, out_out_pkt_count};
        sb.check_result(g);
      end
    end
  end

  task automatic send_item(packet_t p);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_operation = p.op;
    in_host_addr = p.host;
    in_ip_proto = p.proto;
    in_direction = p.dir;
    in_port_number = p.port;
    in_payload_len = p.len;
    in_entry_index = p.idx;
    in_class_select = p.csel;
    case (p.op)
      OP_RECORD: n_record++;
      OP_CLEAR:  n_clear++;
      default:   n_read++;
    endcase
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(logic [1:0] op, logic [31:0] host, logic [7:0] proto,
                             logic [1:0] dir, logic [15:0] port, logic [15:0] len,
                             logic [9:0] idx, logic [1:0] csel);
    packet_t p;
    p = '{op, host, proto, dir, port, len, idx, csel};
    send_item(p);
  endtask

  task automatic send_random();
    packet_t p;
    int r;
    r = $urandom_range(99);
    p.op = (r < 65) ? OP_RECORD : (r < 80) ? OP_HOST_RD : (r < 98) ? OP_PORT_RD : OP_CLEAR;
    p.host = host_pool[$urandom_range(7)];
    case ($urandom_range(3))
      0: p.proto = PROTO_TCP;
      1: p.proto = PROTO_UDP;
      2: p.proto = PROTO_ICMP;
      default: p.proto = 8'($urandom_range(255));
    endcase
    p.dir = 2'($urandom_range(3));
    p.port = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(5));
    p.len = 16'($urandom_range(65535));
    p.idx = ($urandom_range(7) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(15));
    p.csel = 2'($urandom_range(3));
    send_item(p);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_operation = OP_RECORD;
    in_host_addr = '0;
    in_ip_proto = '0;
    in_direction = DIR_IN;
    in_port_number = '0;
    in_payload_len = '0;
    in_entry_index = '0;
    in_class_select = '0;
    hold_req = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Directed: empty reads, field extremes, every class and direction.
    send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, '0, '0);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd1023, '0);
    send_fields(OP_RECORD, 32'hFFFF_FFFF, PROTO_TCP, DIR_IN, 16'hFFFF, 16'hFFFF, '0, '0);
    send_fields(OP_RECORD, 32'h0, PROTO_UDP, DIR_OUT, 16'd1, 16'd0, '0, '0);
    send_fields(OP_RECORD, 32'hFFFF_FFFF, PROTO_ICMP, DIR_NONE, 16'd7, 16'd100, '0, '0);
    send_fields(OP_RECORD, 32'h0, 8'hFF, 2'd3, 16'd9, 16'd55, '0, '0);
    send_fields(OP_RECORD, 32'hFFFF_FFFF, PROTO_TCP, DIR_OUT, 16'd0, 16'd300, '0, '0);
    send_fields(OP_RECORD, 32'hFFFF_FFFF, PROTO_TCP, DIR_OUT, 16'hFFFF, 16'hFFFF, '0, '0);
    send_fields(OP_RECORD, 32'h0, PROTO_UDP, DIR_NONE, 16'd2, 16'd5, '0, '0);
    send_fields(OP_RECORD, 32'h0, 8'h0, DIR_IN, 16'd3, 16'd12, '0, '0);
    for (int c = 0; c < 4; c++) begin
      send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd0, c[1:0]);
      send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd1, c[1:0]);
    end
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd0, '0);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd1, '0);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd2, '0);
    // A host index past the table end reads as empty.
    send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd1023, 2'd3);
    send_fields(OP_CLEAR, '0, '0, DIR_IN, '0, '0, '0, '0);
    send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd0, '0);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
      rcv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 9 : 0;
      for (int i = 0; i < 8; i++) host_pool[i] = $urandom();
      if (phase == 0) hold_req = 1;
      for (int i = 0; i < 250; i++) begin
        // Short stretches without any idling.
        if (i == 110) begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        if (i == 140) begin
          snd_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
          rcv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 9 : 0;
        end
        send_random();
      end
      wait_idle();
    end

    // Fill both tables: 256 hosts with four TCP ports each, then overflow.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_fields(OP_CLEAR, '0, '0, DIR_IN, '0, '0, '0, '0);
    for (int h = 0; h < HOSTS; h++)
      for (int k = 1; k <= 4; k++)
        send_fields(OP_RECORD, 32'h0A00_0000 + h, PROTO_TCP, DIR_IN, k[15:0], 16'd40,
                    '0, '0);
    send_fields(OP_RECORD, 32'h0A00_0005, PROTO_UDP, DIR_OUT, 16'd80, 16'd64, '0, '0);
    send_fields(OP_RECORD, 32'h0A00_0005, PROTO_TCP, DIR_OUT, 16'd2, 16'd64, '0, '0);
    send_fields(OP_RECORD, 32'hC0A8_0001, PROTO_TCP, DIR_IN, 16'd80, 16'd64, '0, '0);
    send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd5, CLS_TCP);
    send_fields(OP_HOST_RD, '0, '0, DIR_IN, '0, '0, 10'd255, CLS_TCP);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd21, '0);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd1023, '0);
    send_fields(OP_CLEAR, '0, '0, DIR_IN, '0, '0, '0, '0);
    send_fields(OP_PORT_RD, '0, '0, DIR_IN, '0, '0, 10'd0, '0);
    wait_idle();

    $display("covered %0d records, %0d reads, %0d clears; %0d results checked",
             n_record, n_read, n_clear, sb.checked);
    $display("including both tables filled to overflow and a long output hold-off");
    if (sb.errors == 0) begin
      $display("** host_traffic_counter_table_unit: PASSED **");
    end else begin
      $display("** host_traffic_counter_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/htc_pkg.sv
hw/rtl/htc_ram.sv
hw/rtl/htc_ctrl.sv
hw/rtl/htc_dp.sv
hw/rtl/host_traffic_counter_table_unit.sv
verif/tb_host_traffic_counter_table_unit.sv
